/* rtl/core/slr_total_delay_mapping_macros.svh */
// assertion macros for the total delay mapping block
// used by the port checker; no other dependencies
`ifndef SLR_TOTAL_DELAY_MAPPING_MACROS_SVH
`define SLR_TOTAL_DELAY_MAPPING_MACROS_SVH

// checked outside reset
`define TDM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define TDM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* rtl/core/tdm_pkg.sv */
// shared types, constants and elaboration-time constant builders
// no dependencies
package tdm_pkg;

   localparam int ANGLE_ITERATIONS = 24;
   localparam int DIV_W            = 64;
   localparam int DIV_STAGES       = DIV_W;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
   localparam int CORDIC_W         = 34;
   localparam int ANGLE_W          = 62;
   localparam int ACC_W            = 48;
   localparam int A_W              = 40;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
   localparam logic signed [34:0] TC_OFFSET = 35'sd4582696550;
   localparam logic [22:0] LAT_LIMIT = 23'd5898240;
   localparam logic [22:0] ELEV_LOW  = 23'd65536;
   localparam logic [22:0] ELEV_HIGH = 23'd5898240;
   localparam logic [63:0] ONE_Q40   = 64'd1 << 40;

   typedef struct packed {
      logic [22:0]        lat_mag;
      logic signed [24:0] height_mm;
      logic [16:0]        temperature;
      logic [22:0]        elevation;
   } tdm_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tdm_qstat_type;

   // unsigned 64-bit long division, only evaluated while building constants
   function automatic logic [63:0] const_div(logic [63:0] n, logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // pi/4 in q62 from truncated machin series
   function automatic logic [63:0] quarter_pi_q62();
      logic [63:0] term;
      logic [63:0] sum5;
      logic [63:0] sum239;
      logic [63:0] odd;
      sum5 = '0;
      term = const_div(64'd1 << 62, 64'd5);
      for (int k = 0; k < 64; k++) begin
         if (term != 0) begin
            odd = 64'(2 * k + 1);
            if (k[0]) sum5 = sum5 - const_div(term, odd);
            else sum5 = sum5 + const_div(term, odd);
            term = const_div(term, 64'd25);
         end
      end
      sum239 = '0;
      term = const_div(64'd1 << 62, 64'd239);
      for (int k = 0; k < 64; k++) begin
         if (term != 0) begin
            odd = 64'(2 * k + 1);
            if (k[0]) sum239 = sum239 - const_div(term, odd);
            else sum239 = sum239 + const_div(term, odd);
            term = const_div(term, 64'd57121);
         end
      end
      return 64'd4 * sum5 - sum239;
   endfunction

   // atan(2^-i) in q58
   function automatic logic [ANGLE_W-1:0] atan_q58(int i);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] odd;
      if (i == 0) return ANGLE_W'(quarter_pi_q62() >> 4);
      sum = '0;
      term = 64'd1 << (62 - i);
      for (int k = 0; k < 64; k++) begin
         if (term != 0) begin
            odd = 64'(2 * k + 1);
            if (k[0]) sum = sum - const_div(term, odd);
            else sum = sum + const_div(term, odd);
            term = term >> (2 * i);
         end
      end
      return ANGLE_W'(sum >> 4);
   endfunction

   // decimal mantissa * 10^-e rounded to f fraction bits
   function automatic logic signed [63:0] dec_fix(int m, int e, int f);
      logic [63:0] mag;
      logic [63:0] p5;
      logic [63:0] r;
      mag = (m < 0) ? 64'(-m) : 64'(m);
      p5 = 64'd1;
      for (int j = 0; j < e; j++) p5 = p5 * 64'd5;
      r = const_div((mag << (f - e)) + (p5 >> 1), p5);
      return (m < 0) ? -$signed(r) : $signed(r);
   endfunction

   localparam logic [63:0] QPI      = quarter_pi_q62();
   localparam logic [63:0] D2R_FULL = const_div(64'd4 * QPI, 64'd180) >> 20;
   localparam logic [36:0] D2R      = D2R_FULL[36:0];

   localparam logic signed [ACC_W-1:0] COEF_BASE [3] = '{
      ACC_W'(dec_fix(121008, 8, 40)), ACC_W'(dec_fix(304965, 8, 40)),
      ACC_W'(dec_fix(68777, 6, 40))};
   localparam logic signed [25:0] COEF_TEMP [3] = '{
      26'(dec_fix(17295, 10, 40)), 26'(dec_fix(2346, 9, 40)),
      26'(dec_fix(1972, 8, 40))};
   localparam logic signed [33:0] COEF_COSLAT [3] = '{
      34'(dec_fix(3191, 8, 40)), 34'(dec_fix(-1035, 7, 40)),
      34'(dec_fix(-3458, 6, 40))};
   localparam logic signed [32:0] COEF_HEIGHT [3] = '{
      33'(dec_fix(-18478, 15, 56)), 33'(dec_fix(-1856, 14, 56)),
      33'(dec_fix(106, 12, 56))};

endpackage

/* rtl/core/slr_total_delay_mapping.sv */
// throughput: one word per cycle; the pipeline holds while rsp_stall keeps a word waiting
// depth is set by the 24-stage cordic and three 64-stage divider pipelines in series
// reset: synchronous, active high, clears every valid bit and the queue but not rsp data
// depends on tdm_pkg, tdm_front, tdm_queue, tdm_back
module slr_total_delay_mapping (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_latitude,
   input  logic signed [24:0] req_height_mm,
   input  logic [16:0]        req_temperature,
   input  logic [22:0]        req_elevation,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_mapping_value
);
   import tdm_pkg::*;

   // front to queue
   logic          push;
   tdm_item_type  front_item;
   // queue to back
   tdm_item_type  head;
   tdm_qstat_type qstat;
   logic          pop;

   // front: registers the word, clamps latitude magnitude and elevation
   tdm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_latitude    (req_latitude),
      .req_height_mm   (req_height_mm),
      .req_temperature (req_temperature),
      .req_elevation   (req_elevation),
      .qstat           (qstat),
      .push            (push),
      .item            (front_item)
   );

   // four-word queue lets the front keep taking words while the back holds
   tdm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (front_item),
      .pop     (pop),
      .head    (head),
      .qstat   (qstat)
   );

   // back: cordic for cos(lat) and sin(elev), coefficient lanes,
   // zenith and slant continued fractions side by side, final rounded ratio
   tdm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .qstat             (qstat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mapping_value (rsp_mapping_value)
   );
endmodule

/* rtl/core/tdm_front.sv */
// front stage: takes a word, clamps the angles, hands it to the queue
// depends on tdm_pkg
module tdm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [23:0]    req_latitude,
   input  logic signed [24:0]    req_height_mm,
   input  logic [16:0]           req_temperature,
   input  logic [22:0]           req_elevation,
   input  tdm_pkg::tdm_qstat_type qstat,
   output logic                  push,
   output tdm_pkg::tdm_item_type item
);
   import tdm_pkg::*;

   logic         hold_valid_ff, hold_valid_in;
   tdm_item_type hold_ff, hold_in;
   logic [23:0]  lat_abs;
   logic         load;

   assign push      = hold_valid_ff && !qstat.full;
   assign req_stall = hold_valid_ff && qstat.full;
   assign load      = req_valid && !req_stall;
   assign item      = hold_ff;

   always_comb begin
      lat_abs = req_latitude[23] ? 24'(-req_latitude) : req_latitude;
      hold_in.lat_mag = (lat_abs > {1'b0, LAT_LIMIT}) ? LAT_LIMIT : lat_abs[22:0];
      hold_in.height_mm = req_height_mm;
      hold_in.temperature = req_temperature;
      if (req_elevation < ELEV_LOW) hold_in.elevation = ELEV_LOW;
      else if (req_elevation > ELEV_HIGH) hold_in.elevation = ELEV_HIGH;
      else hold_in.elevation = req_elevation;
      hold_valid_in = load || (hold_valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) hold_valid_ff <= 1'b0;
      else hold_valid_ff <= hold_valid_in;
      if (load) hold_ff <= hold_in;
   end
endmodule

/* rtl/core/tdm_queue.sv */
// short fifo between the front stage and the pipeline
// depends on tdm_pkg
module tdm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tdm_pkg::tdm_item_type  wr_item,
   input  logic                   pop,
   output tdm_pkg::tdm_item_type  head,
   output tdm_pkg::tdm_qstat_type qstat
);
   import tdm_pkg::*;

   tdm_item_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign head        = mem_ff[rd_ff];
   assign qstat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) mem_ff[wr_ff] <= wr_item;
   end
endmodule

/* rtl/core/tdm_cordic.sv */
// pipelined rotation-mode cordic, one iteration per stage
// depends on tdm_pkg
module tdm_cordic (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [59:0]                         angle,
   output logic signed [tdm_pkg::CORDIC_W-1:0] sin_out,
   output logic signed [tdm_pkg::CORDIC_W-1:0] cos_out
);
   import tdm_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [ANGLE_ITERATIONS];
   logic signed [CORDIC_W-1:0] y_ff [ANGLE_ITERATIONS];
   logic signed [ANGLE_W-1:0]  z_ff [ANGLE_ITERATIONS];

   for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_stage
      localparam logic signed [ANGLE_W-1:0] STEP = atan_q58(i);
      logic signed [CORDIC_W-1:0] x_src, y_src, x_in, y_in;
      logic signed [ANGLE_W-1:0]  z_src, z_in;

      if (i == 0) begin : g_first
         assign x_src = CORDIC_GAIN;
         assign y_src = '0;
         assign z_src = $signed({2'b00, angle});
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
      end

      always_comb begin
         if (z_src >= 0) begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
            z_in = z_src - STEP;
         end else begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
            z_in = z_src + STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign sin_out = y_ff[ANGLE_ITERATIONS-1];
   assign cos_out = x_ff[ANGLE_ITERATIONS-1];
endmodule

/* rtl/core/tdm_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on tdm_pkg
module tdm_div (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [tdm_pkg::DIV_W-1:0]   num,
   input  logic [tdm_pkg::DIV_W-1:0]   den,
   output logic [tdm_pkg::DIV_W-1:0]   quo
);
   import tdm_pkg::*;

   logic [DIV_W-1:0] n_ff [DIV_STAGES];
   logic [DIV_W-1:0] r_ff [DIV_STAGES];
   logic [DIV_W-1:0] d_ff [DIV_STAGES];
   logic [DIV_W-1:0] q_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_W-1:0] n_src, r_src, d_src, q_src, r_in;
      logic [DIV_W:0]   trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign n_src = num;
         assign r_src = '0;
         assign d_src = den;
         assign q_src = '0;
      end else begin : g_next
         assign n_src = n_ff[k-1];
         assign r_src = r_ff[k-1];
         assign d_src = d_ff[k-1];
         assign q_src = q_ff[k-1];
      end

      always_comb begin
         trial = {r_src, n_src[DIV_W-1]};
         ge = (trial >= {1'b0, d_src});
         r_in = ge ? DIV_W'(trial - {1'b0, d_src}) : trial[DIV_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            n_ff[k] <= n_src << 1;
            r_ff[k] <= r_in;
            d_ff[k] <= d_src;
            q_ff[k] <= {q_src[DIV_W-2:0], ge};
         end
      end
   end

   assign quo = q_ff[DIV_STAGES-1];
endmodule

/* rtl/core/tdm_back.sv */
// back pipeline: angles, coefficients, continued fractions, ratio
// depends on tdm_pkg, tdm_cordic, tdm_div
module tdm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tdm_pkg::tdm_item_type  head,
   input  tdm_pkg::tdm_qstat_type qstat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_mapping_value
);
   import tdm_pkg::*;

   function automatic logic [63:0] guard_den(logic [63:0] v);
      return (v == '0) ? 64'd1 : v;
   endfunction

   logic adv;

   // angle stage
   logic               v0_ff;
   logic [59:0]        ang_lat_ff, ang_el_ff;
   logic signed [34:0] tc_ff;
   logic signed [24:0] h_ff;

   // side line alongside the cordic
   logic [ANGLE_ITERATIONS-1:0] cv_ff;
   logic signed [34:0]          ctc_ff [ANGLE_ITERATIONS];
   logic signed [24:0]          ch_ff  [ANGLE_ITERATIONS];
   logic signed [CORDIC_W-1:0]  cos_lat, sin_el;

   // product and sum stages
   logic        v1_ff, v2_ff;
   logic [63:0] sden1_ff, sden2_ff;
   logic [A_W-1:0] a_ff [3];

   // divider levels
   logic [63:0] qz1, qd1, qz2, qd2, q3;
   logic [DIV_STAGES-1:0] l1v_ff, l2v_ff, l3v_ff;
   logic [63:0] l1s_ff [DIV_STAGES];
   logic [33:0] l1a_ff [DIV_STAGES];
   logic [63:0] l2s_ff [DIV_STAGES];
   logic [63:0] zen, den, d3, num3;

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = !qstat.empty && adv;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= !qstat.empty;
      if (adv) begin
         ang_lat_ff <= 60'(head.lat_mag) * 60'(D2R);
         ang_el_ff <= 60'(head.elevation) * 60'(D2R);
         tc_ff <= $signed({2'b00, head.temperature, 16'h0000}) - TC_OFFSET;
         h_ff <= head.height_mm;
      end
   end

   tdm_cordic u_cordic_lat (
      .clock   (clock),
      .advance (adv),
      .angle   (ang_lat_ff),
      .sin_out (),
      .cos_out (cos_lat)
   );

   tdm_cordic u_cordic_el (
      .clock   (clock),
      .advance (adv),
      .angle   (ang_el_ff),
      .sin_out (sin_el),
      .cos_out ()
   );

   always_ff @(posedge clock) begin
      if (reset) cv_ff <= '0;
      else if (adv) cv_ff <= {cv_ff[ANGLE_ITERATIONS-2:0], v0_ff};
      if (adv) begin
         ctc_ff[0] <= tc_ff;
         ch_ff[0] <= h_ff;
         for (int i = 1; i < ANGLE_ITERATIONS; i++) begin
            ctc_ff[i] <= ctc_ff[i-1];
            ch_ff[i] <= ch_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= cv_ff[ANGLE_ITERATIONS-1];
         v2_ff <= v1_ff;
      end
      if (adv) begin
         sden1_ff <= sin_el[CORDIC_W-1] ? 64'd0 : ({30'd0, sin_el} << 10);
         sden2_ff <= sden1_ff;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_coef
      logic signed [60:0]      p_temp_ff;
      logic signed [67:0]      p_cos_ff;
      logic signed [57:0]      p_h_ff;
      logic signed [ACC_W-1:0] acc;

      always_comb begin
         acc = COEF_BASE[k] + ACC_W'(p_temp_ff >>> 24) + ACC_W'(p_cos_ff >>> 30)
             + ACC_W'(p_h_ff >>> 16);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            p_temp_ff <= 61'(COEF_TEMP[k]) * 61'(ctc_ff[ANGLE_ITERATIONS-1]);
            p_cos_ff <= 68'(COEF_COSLAT[k]) * 68'(cos_lat);
            p_h_ff <= 58'(COEF_HEIGHT[k]) * 58'(ch_ff[ANGLE_ITERATIONS-1]);
            a_ff[k] <= acc[ACC_W-1] ? '0 : acc[A_W-1:0];
         end
      end
   end

   tdm_div u_div_z1 (
      .clock (clock), .advance (adv),
      .num   ({a_ff[1][33:0], 30'd0}),
      .den   (guard_den((ONE_Q40 + 64'(a_ff[2])) >> 10)),
      .quo   (qz1)
   );

   tdm_div u_div_d1 (
      .clock (clock), .advance (adv),
      .num   ({a_ff[1][33:0], 30'd0}),
      .den   (guard_den((sden2_ff + 64'(a_ff[2])) >> 10)),
      .quo   (qd1)
   );

   tdm_div u_div_z2 (
      .clock (clock), .advance (adv),
      .num   ({l1a_ff[DIV_STAGES-1], 30'd0}),
      .den   (guard_den((ONE_Q40 + qz1) >> 10)),
      .quo   (qz2)
   );

   tdm_div u_div_d2 (
      .clock (clock), .advance (adv),
      .num   ({l1a_ff[DIV_STAGES-1], 30'd0}),
      .den   (guard_den((l1s_ff[DIV_STAGES-1] + qd1) >> 10)),
      .quo   (qd2)
   );

   always_comb begin
      zen = ONE_Q40 + qz2;
      den = l2s_ff[DIV_STAGES-1] + qd2;
      d3 = guard_den(den >> 4);
      num3 = (zen << 20) + (d3 >> 1);
   end

   tdm_div u_div_ratio (
      .clock (clock), .advance (adv),
      .num   (num3),
      .den   (d3),
      .quo   (q3)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         l1v_ff <= '0;
         l2v_ff <= '0;
         l3v_ff <= '0;
      end else if (adv) begin
         l1v_ff <= {l1v_ff[DIV_STAGES-2:0], v2_ff};
         l2v_ff <= {l2v_ff[DIV_STAGES-2:0], l1v_ff[DIV_STAGES-1]};
         l3v_ff <= {l3v_ff[DIV_STAGES-2:0], l2v_ff[DIV_STAGES-1]};
      end
      if (adv) begin
         l1s_ff[0] <= sden2_ff;
         l1a_ff[0] <= a_ff[0][33:0];
         l2s_ff[0] <= l1s_ff[DIV_STAGES-1];
         for (int i = 1; i < DIV_STAGES; i++) begin
            l1s_ff[i] <= l1s_ff[i-1];
            l1a_ff[i] <= l1a_ff[i-1];
            l2s_ff[i] <= l2s_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= l3v_ff[DIV_STAGES-1];
      if (adv) rsp_value_ff <= (q3[63:32] != '0) ? 32'hFFFF_FFFF : q3[31:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mapping_value = rsp_value_ff;
endmodule

/* rtl/core/tdm_checker.sv */
// port-level checker for the total delay mapping block, bound to the top level
// depends on tdm_pkg and slr_total_delay_mapping_macros.svh
`include "slr_total_delay_mapping_macros.svh"

module tdm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_mapping_value
);
   import tdm_pkg::*;

   logic [9:0] inflight_ff, inflight_in;
   logic       in_acc, out_acc, rsp_wait;

   assign in_acc   = req_valid && !req_stall;
   assign out_acc  = rsp_valid && !rsp_stall;
   assign rsp_wait = rsp_valid && rsp_stall;

   always_comb begin
      inflight_in = inflight_ff + 10'(in_acc) - 10'(out_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= '0;
      else inflight_ff <= inflight_in;
   end

   `TDM_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_valid && !req_stall, "busy after reset")
   `TDM_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_mapping_value), "rsp word moved")
   `TDM_ASSERT(a_no_phantom, rsp_valid |-> inflight_ff != 10'd0, "rsp word with nothing in flight")
   `TDM_ASSERT(a_stall_backlog, req_stall |-> inflight_ff > 10'(QUEUE_DEPTH), "early req stall")
endmodule

bind slr_total_delay_mapping tdm_checker u_checker (.*);

/* verif/testbench.sv */
// self-checking testbench for slr_total_delay_mapping
// depends on the rtl top level and tdm_pkg; carries its own bit-exact mapping predictor
`timescale 1ns / 1ps

module testbench;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 260;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [23:0] req_latitude = '0;
   logic signed [24:0] req_height_mm = '0;
   logic [16:0]        req_temperature = '0;
   logic [22:0]        req_elevation = tdm_pkg::ELEV_LOW;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [31:0]        rsp_mapping_value;

   slr_total_delay_mapping dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_latitude      (req_latitude),
      .req_height_mm     (req_height_mm),
      .req_temperature   (req_temperature),
      .req_elevation     (req_elevation),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mapping_value (rsp_mapping_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // expected mapping values, oldest first
   logic [31:0] mapping_due [$];
   int          error_count = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          quiet_cycles = 0;

   // ---------------------------------------------------------------
   // predictor constants, built once at time zero
   // ---------------------------------------------------------------
   longint unsigned quarter_pi;
   longint unsigned deg_to_rad;
   longint          rot_angle [24];
   longint          coef_c0 [3];
   longint          coef_c1 [3];
   longint          coef_c2 [3];
   longint          coef_c3 [3];

   // truncated alternating arctangent series; term shrinks by div or by a shift
   function automatic longint unsigned arctan_sum(longint unsigned term, longint unsigned div,
                                                  int sh);
      longint unsigned acc;
      longint unsigned k;
      acc = 0;
      k = 0;
      while (term != 0) begin
         if (k[0]) acc = acc - term / (2 * k + 1);
         else acc = acc + term / (2 * k + 1);
         if (sh != 0) term = (sh >= 64) ? 64'd0 : (term >> sh);
         else term = term / div;
         k++;
      end
      return acc;
   endfunction

   // decimal mantissa times 10^-e, rounded to f fraction bits
   function automatic longint decimal_to_fixed(int m, int e, int f);
      longint unsigned mag;
      longint unsigned p5;
      longint unsigned r;
      mag = (m < 0) ? longint'(-m) : longint'(m);
      p5 = 1;
      for (int j = 0; j < e; j++) p5 = p5 * 5;
      r = ((mag << (f - e)) + p5 / 2) / p5;
      return (m < 0) ? -longint'(r) : longint'(r);
   endfunction

   initial begin
      int mant [3][4];
      int expo [3][4];
      mant = '{'{121008, 17295, 3191, -18478}, '{304965, 2346, -1035, -1856},
               '{68777, 1972, -3458, 106}};
      expo = '{'{8, 10, 8, 15}, '{8, 9, 7, 14}, '{6, 8, 6, 12}};
      quarter_pi = 4 * arctan_sum((64'd1 << 62) / 5, 25, 0)
                   - arctan_sum((64'd1 << 62) / 239, 57121, 0);
      deg_to_rad = ((4 * quarter_pi) / 180) >> 20;
      rot_angle[0] = longint'(quarter_pi >> 4);
      for (int i = 1; i < 24; i++)
         rot_angle[i] = longint'(arctan_sum(64'd1 << (62 - i), 1, 2 * i) >> 4);
      for (int k = 0; k < 3; k++) begin
         coef_c0[k] = decimal_to_fixed(mant[k][0], expo[k][0], 40);
         coef_c1[k] = decimal_to_fixed(mant[k][1], expo[k][1], 40);
         coef_c2[k] = decimal_to_fixed(mant[k][2], expo[k][2], 40);
         coef_c3[k] = decimal_to_fixed(mant[k][3], expo[k][3], 56);
      end
   end

   // fixed-length rotation, returns sine and cosine in q30
   task automatic rotate_angle(input longint ang, output longint sin_q30,
                               output longint cos_q30);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = 652032874;
      y = 0;
      z = ang;
      for (int i = 0; i < tdm_pkg::ANGLE_ITERATIONS && i < 62; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - rot_angle[i];
         end else begin
            x = x + dx; y = y - dy; z = z + rot_angle[i];
         end
      end
      sin_q30 = y;
      cos_q30 = x;
   endtask

   function automatic longint unsigned quotient_q40(longint unsigned num,
                                                    longint unsigned den);
      longint unsigned d;
      d = den >> 10;
      if (d == 0) d = 1;
      return (num << 30) / d;
   endfunction

   // three-term continued fraction s + a0/(s + a1/(s + a2))
   function automatic longint unsigned fraction_chain(longint unsigned s,
                                                      longint unsigned a0,
                                                      longint unsigned a1,
                                                      longint unsigned a2);
      longint unsigned inner;
      inner = s + a2;
      inner = s + quotient_q40(a1, inner);
      return s + quotient_q40(a0, inner);
   endfunction

   task automatic predict_mapping(input logic [23:0] lat_bits, input logic [24:0] h_bits,
                                  input logic [16:0] t_bits, input logic [22:0] e_bits,
                                  output logic [31:0] value);
      longint          lat;
      longint          hmm;
      longint          elev;
      longint          tc;
      longint          s_lat;
      longint          c_lat;
      longint          s_el;
      longint          c_el;
      longint          v;
      longint unsigned a [3];
      longint unsigned zen;
      longint unsigned den;
      longint unsigned d;
      longint unsigned res;
      lat = longint'($signed(lat_bits));
      if (lat < 0) lat = -lat;
      if (lat > 5898240) lat = 5898240;               // clamp to the pole
      hmm = longint'($signed(h_bits));
      elev = longint'(e_bits);
      if (elev < 65536) elev = 65536;                 // clamp elevation into 1..90 degrees
      if (elev > 5898240) elev = 5898240;
      rotate_angle(lat * longint'(deg_to_rad), s_lat, c_lat);
      rotate_angle(elev * longint'(deg_to_rad), s_el, c_el);
      tc = longint'(t_bits) * 65536 - 64'sd4582696550;
      for (int k = 0; k < 3; k++) begin
         v = coef_c0[k] + ((coef_c1[k] * tc) >>> 24) + ((coef_c2[k] * c_lat) >>> 30)
             + ((coef_c3[k] * hmm) >>> 16);
         a[k] = (v < 0) ? 64'd0 : longint'(v);
      end
      if (s_el < 0) s_el = 0;
      zen = fraction_chain(64'd1 << 40, a[0], a[1], a[2]);
      den = fraction_chain(longint'(s_el) << 10, a[0], a[1], a[2]);
      d = den >> 4;
      if (d == 0) d = 1;
      res = ((zen << 20) + d / 2) / d;
      if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;   // saturate
      value = res[31:0];
   endtask

   // ---------------------------------------------------------------
   // request side: one word per call, random idle cycles before it
   // ---------------------------------------------------------------
   task automatic send_observation(input logic [23:0] lat, input logic [24:0] h,
                                   input logic [16:0] t, input logic [22:0] e);
      logic [31:0] want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_latitude    <= lat;
      req_height_mm   <= h;
      req_temperature <= t;
      req_elevation   <= e;
      do @(posedge clock); while (req_stall);
      // accepted at this edge
      predict_mapping(lat, h, t, e, want);
      mapping_due.push_back(want);
      words_sent++;
   endtask

   // response side stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // compare every accepted rsp word with the oldest expectation
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mapping_due.size() == 0) begin
            $error("unexpected rsp word, mapping_value %0d", rsp_mapping_value);
            error_count++;
         end else begin
            want = mapping_due.pop_front();
            if (rsp_mapping_value !== want) begin
               $error("mapping_value expected %0d actual %0d", want, rsp_mapping_value);
               error_count++;
            end
            words_checked++;
         end
      end
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_field_extremes();
      logic [22:0] deg45;
      deg45 = 23'd2949120;
      // latitude: zero, both poles, just past the north pole, field limits
      send_observation(24'sd0, 25'sd0, 17'd73766, deg45);
      send_observation(24'sd5898240, 25'sd0, 17'd73766, deg45);
      send_observation(-24'sd5898240, 25'sd0, 17'd73766, deg45);
      send_observation(24'sd5898241, 25'sd1000, 17'd73766, deg45);
      send_observation(24'h800000, 25'sd1000, 17'd73766, deg45);
      send_observation(24'h7FFFFF, 25'sd1000, 17'd73766, deg45);
      // height: range ends and field ends
      send_observation(24'sd2000000, -25'sd500000, 17'd70000, deg45);
      send_observation(24'sd2000000, 25'sd9000000, 17'd70000, deg45);
      send_observation(24'sd2000000, 25'h1000000, 17'd70000, deg45);
      send_observation(24'sd2000000, 25'h0FFFFFF, 17'd70000, deg45);
      // temperature: absolute zero, range top, field top
      send_observation(24'sd3000000, 25'sd50000, 17'd0, deg45);
      send_observation(24'sd3000000, 25'sd50000, 17'd102400, deg45);
      send_observation(24'sd3000000, 25'sd50000, 17'h1FFFF, deg45);
      // elevation: below one degree, one degree, zenith, past zenith
      send_observation(24'sd3000000, 25'sd50000, 17'd73766, 23'd0);
      send_observation(24'sd3000000, 25'sd50000, 17'd73766, 23'd65535);
      send_observation(24'sd3000000, 25'sd50000, 17'd73766, 23'd65536);
      send_observation(24'sd3000000, 25'sd50000, 17'd73766, 23'd5898240);
      send_observation(24'sd3000000, 25'sd50000, 17'd73766, 23'h7FFFFF);
      send_observation(-24'sd1000000, 25'sd2000000, 17'd60000, 23'd131072);
      // every field at its largest pattern and at all zeros
      send_observation(24'hFFFFFF, 25'h1FFFFFF, 17'h1FFFF, 23'h7FFFFF);
      send_observation(24'h000000, 25'h0000000, 17'h00000, 23'h000000);
   endtask

   task automatic test_random_observations(input int n, input int s_pct, input int r_pct);
      logic [23:0] lat;
      logic [24:0] h;
      logic [16:0] t;
      logic [22:0] e;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n) begin
         if ($urandom_range(9) == 0) begin
            // raw field patterns, out of range included
            lat = 24'($urandom);
            h   = 25'($urandom);
            t   = 17'($urandom);
            e   = 23'($urandom);
         end else begin
            lat = 24'($urandom_range(11796480) - 5898240);
            h   = 25'($urandom_range(9500000) - 500000);
            t   = ($urandom_range(3) == 0) ? 17'($urandom_range(102400))
                                           : 17'($urandom_range(84000, 58000));
            e   = 23'($urandom_range(5898240, 65536));
         end
         send_observation(lat, h, t, e);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 27;
      recv_idle_pct = 64;
      test_field_extremes();
      test_random_observations(440, 27, 64);
      test_random_observations(440, 64, 27);
      test_random_observations(450, 0, 0);
      req_valid <= 1'b0;
      wait (mapping_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d observations, %0d results checked, field extremes and clamps",
               words_sent, words_checked);
      $display("idle mixes: sender 27 / receiver 64, sender 64 / receiver 27, no idling");
      if (error_count == 0 && mapping_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
